// File: rtl/lnp_pkg.sv
package lnp_pkg;

  localparam int LNP_POOL_NODES = 512;

  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int NODE_W = 9;
  localparam int STAT_W = 2;

  // in_tdata: position, value; out_tdata: removed_value, node_index
  localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + NODE_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TUSER_W = STAT_W;

  typedef enum logic {
    MODE_INS = 1'b0,
    MODE_DEL = 1'b1
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NULL_POS  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NO_NEXT   = 2'd3
  } stat_t;

  typedef struct packed {
    logic  clr;      // init pass: write one link entry
    logic  load;     // latch input beat
    logic  rd_ins;   // read link[free_head] and link[pos]
    logic  rd_pos;   // read link[pos]
    logic  rd_next;  // read link[q] and value[q], q = link[pos]
    logic  wr_ins1;  // link[q] <= link[pos], value[q] <= value, pop free head
    logic  wr_ins2;  // link[pos] <= q
    logic  wr_del1;  // link[pos] <= link[q]
    logic  wr_del2;  // link[q] <= free head, push q
    logic  out_load;
    stat_t out_status;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pos_null;
    logic mode_del;
    logic fh_valid;
    logic nxt_valid;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/lnp_ctrl.sv
module lnp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  lnp_pkg::sts_t sts,
  output lnp_pkg::cmd_t cmd
);
  import lnp_pkg::*;

  typedef enum logic [8:0] {
    S_INIT   = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_CHK    = 9'b000000100,
    S_INS_W1 = 9'b000001000,
    S_INS_W2 = 9'b000010000,
    S_DEL_RD = 9'b000100000,
    S_DEL_W1 = 9'b001000000,
    S_DEL_W2 = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;
  stat_t  res_r, res_nxt;

  always_comb begin
    cmd            = '0;
    cmd.out_status = res_r;
    st_nxt         = st_r;
    res_nxt        = res_r;
    in_tready      = 1'b0;
    case (st_r)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          st_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.pos_null) begin
          res_nxt = ST_NULL_POS;
          st_nxt  = S_FIN;
        end else if (!sts.mode_del) begin
          if (!sts.fh_valid) begin
            res_nxt = ST_EXHAUSTED;
            st_nxt  = S_FIN;
          end else begin
            cmd.rd_ins = 1'b1;
            st_nxt     = S_INS_W1;
          end
        end else begin
          cmd.rd_pos = 1'b1;
          st_nxt     = S_DEL_RD;
        end
      end
      S_INS_W1: begin
        cmd.wr_ins1 = 1'b1;
        st_nxt      = S_INS_W2;
      end
      S_INS_W2: begin
        cmd.wr_ins2 = 1'b1;
        res_nxt     = ST_OK;
        st_nxt      = S_FIN;
      end
      S_DEL_RD: begin
        if (!sts.nxt_valid) begin
          res_nxt = ST_NO_NEXT;
          st_nxt  = S_FIN;
        end else begin
          cmd.rd_next = 1'b1;
          st_nxt      = S_DEL_W1;
        end
      end
      S_DEL_W1: begin
        cmd.wr_del1 = 1'b1;
        st_nxt      = S_DEL_W2;
      end
      S_DEL_W2: begin
        cmd.wr_del2 = 1'b1;
        res_nxt     = ST_OK;
        st_nxt      = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_INIT;
      res_r <= ST_OK;
    end else begin
      st_r  <= st_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

// File: rtl/lnp_dpath.sv
module lnp_dpath #(
  parameter int POOL_NODES = lnp_pkg::LNP_POOL_NODES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lnp_pkg::cmd_t                   cmd,
  output lnp_pkg::sts_t                   sts,
  input  logic [lnp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [lnp_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lnp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [lnp_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import lnp_pkg::*;

  localparam int IW = $clog2(POOL_NODES);
  localparam logic [IW-1:0] LAST = IW'(POOL_NODES - 1);

  // link entry: [IW] valid, [IW-1:0] node index
  logic [IW:0]       link_mem [POOL_NODES];
  logic [VAL_W-1:0]  val_mem  [POOL_NODES];

  logic [IW-1:0]     clr_cnt_r;
  logic [IW:0]       fh_r;
  mode_t             mode_r;
  logic [IW-1:0]     pos_r;
  logic              null_r;
  logic [VAL_W-1:0]  val_r;
  logic [IW-1:0]     q_r;
  logic [IW:0]       lnk_a_r;
  logic [IW:0]       lnk_b_r;
  logic [VAL_W-1:0]  val_rd_r;

  logic              out_valid_r;
  stat_t             out_stat_r;
  logic [VAL_W-1:0]  out_val_r;
  logic [NODE_W-1:0] out_node_r;

  logic [POS_W-1:0]  pos_raw;
  logic              rd_a_en;
  logic [IW-1:0]     rd_a_addr;
  logic              rd_b_en;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [IW:0]       wr_data;

  assign pos_raw = in_tdata[POS_W-1:0];

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = q_r;
    wr_data = lnk_b_r;
    if (cmd.clr) begin
      wr_addr = clr_cnt_r;
      wr_data = {clr_cnt_r != LAST, clr_cnt_r + 1'b1};
    end else if (cmd.wr_ins1) begin
      wr_addr = q_r;
      wr_data = lnk_b_r;
    end else if (cmd.wr_ins2) begin
      wr_addr = pos_r;
      wr_data = {1'b1, q_r};
    end else if (cmd.wr_del1) begin
      wr_addr = pos_r;
      wr_data = lnk_a_r;
    end else if (cmd.wr_del2) begin
      wr_addr = q_r;
      wr_data = fh_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  assign rd_a_en   = cmd.rd_ins | cmd.rd_next;
  assign rd_a_addr = cmd.rd_ins ? fh_r[IW-1:0] : lnk_b_r[IW-1:0];
  assign rd_b_en   = cmd.rd_ins | cmd.rd_pos;

  always_ff @(posedge clk) begin
    if (rd_a_en) lnk_a_r <= link_mem[rd_a_addr];
    if (rd_b_en) lnk_b_r <= link_mem[pos_r];
    if (wr_en)   link_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_next) val_rd_r <= val_mem[lnk_b_r[IW-1:0]];
    if (cmd.wr_ins1) val_mem[q_r] <= val_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_tuser[0]);
      pos_r  <= IW'(pos_raw);
      null_r <= pos_raw[POS_W-1] ||
                ({{(32-POS_W){1'b0}}, pos_raw} >= 32'(POOL_NODES));
      val_r  <= in_tdata[POS_W +: VAL_W];
    end
    if (cmd.rd_ins)  q_r <= fh_r[IW-1:0];
    if (cmd.rd_next) q_r <= lnk_b_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      fh_r      <= {1'b1, {IW{1'b0}}};
    end else begin
      if (cmd.clr)     clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.wr_ins1) fh_r      <= lnk_a_r;
      if (cmd.wr_del2) fh_r      <= {1'b1, q_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_stat_r <= cmd.out_status;
      out_val_r  <= (cmd.out_status == ST_OK && mode_r == MODE_DEL) ? val_rd_r : '0;
      out_node_r <= (cmd.out_status == ST_OK) ? NODE_W'(q_r) : '0;
    end
  end

  assign sts.clr_done  = (clr_cnt_r == LAST);
  assign sts.pos_null  = null_r;
  assign sts.mode_del  = (mode_r == MODE_DEL);
  assign sts.fh_valid  = fh_r[IW];
  assign sts.nxt_valid = lnk_b_r[IW];
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {{(OUT_TDATA_W-VAL_W-NODE_W){1'b0}}, out_node_r, out_val_r};

endmodule

// File: rtl/linked_node_pool_insert_delete_core.sv
// Node pool with a free chain: each input beat inserts a value after a node
// or deletes the node that follows it, and gives exactly one result beat.
// in_*  : tuser = mode (0 insert, 1 delete); tdata = position, value.
// out_* : tuser = status (ok, null position, pool exhausted, no next node);
//         tdata = removed value, node index (both zero unless ok).
// One item is worked at a time; in_tready is high only while idle.
// An insert reads the free head and link[pos], then writes link[q] and
// link[pos]; a delete reads link[pos], then link[q] and value[q], then writes
// link[pos] and link[q]. A null position or an empty pool ends the item at
// the check, and a delete with no next node after reading link[pos]. The
// steps follow from the dependent reads of the link memory and its single
// write port, one link written per cycle. After reset the block walks the
// link memory once to build the free chain; in_tready stays low meanwhile.
// A result sits in the output register until taken; the next input beat is
// accepted meanwhile, and its result waits until the register is free.
module linked_node_pool_insert_delete_core #(
  parameter int POOL_NODES = lnp_pkg::LNP_POOL_NODES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lnp_pkg::IN_TDATA_W-1:0]  in_tdata,   // position[9:0], value[41:10]
  input  logic [lnp_pkg::IN_TUSER_W-1:0]  in_tuser,   // mode[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lnp_pkg::OUT_TDATA_W-1:0] out_tdata,  // removed_value[31:0], node_index[40:32]
  output logic [lnp_pkg::OUT_TUSER_W-1:0] out_tuser   // status[1:0]
);
  import lnp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lnp_dpath #(
    .POOL_NODES (POOL_NODES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/lnp_chk.sv
module lnp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [lnp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [lnp_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lnp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [lnp_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import lnp_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a failed operation reports no node and no value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero payload on error status");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // reset clears the result and keeps in_tready low as the init pass starts
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind linked_node_pool_insert_delete_core lnp_chk u_lnp_chk (.*);
